### rtl/core/biquad_or_comb_audio_filter_defines.svh
// Assertion macros shared by the audio filter RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef BIQUAD_OR_COMB_AUDIO_FILTER_DEFINES_SVH
`define BIQUAD_OR_COMB_AUDIO_FILTER_DEFINES_SVH

// Checked on every rising clock edge outside of reset.
`define BQC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define BQC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/bqcomb_pkg.sv
// Package for the biquad / comb audio filter: sequencer states, register
// indexes, field widths and default parameter values. No dependencies.
`timescale 1ns / 1ps

package bqcomb_pkg;

   // Default parameter values
   localparam int DELAY_LENGTH_DEF = 1024;
   localparam int SAMPLE_WIDTH_DEF = 16;

   // Fixed field widths
   localparam int COEF_W = 16;   // signed Q2.13 coefficients
   localparam int A0_W   = 15;   // unsigned normalizer
   localparam int CSR_AW = 3;    // register index width
   localparam int CSR_DW = 16;   // widest register

   // Register indexes
   localparam logic [CSR_AW-1:0] REG_FILTER_MODE = 3'd0;
   localparam logic [CSR_AW-1:0] REG_COEF_A0     = 3'd1;
   localparam logic [CSR_AW-1:0] REG_COEF_A1     = 3'd2;
   localparam logic [CSR_AW-1:0] REG_COEF_A2     = 3'd3;
   localparam logic [CSR_AW-1:0] REG_COEF_B0     = 3'd4;
   localparam logic [CSR_AW-1:0] REG_COEF_B1     = 3'd5;
   localparam logic [CSR_AW-1:0] REG_COEF_B2     = 3'd6;
   localparam logic [CSR_AW-1:0] REG_COMB_GAIN   = 3'd7;

   // Filter modes
   localparam logic MODE_BIQUAD = 1'b0;
   localparam logic MODE_COMB   = 1'b1;

   // Reset values of the coefficients (1.0 in Q2.13)
   localparam logic [A0_W-1:0]          A0_RESET   = 15'd8192;
   localparam logic signed [COEF_W-1:0] UNITY_COEF = 16'sd8192;

   // Comb product rounding: add half an LSB, then shift by 13
   localparam int COMB_SHIFT = 13;
   localparam int COMB_ROUND = 4096;

   // Multiply-accumulate steps of the biquad
   localparam logic [2:0] MAC_B0   = 3'd0;
   localparam logic [2:0] MAC_B1   = 3'd1;
   localparam logic [2:0] MAC_B2   = 3'd2;
   localparam logic [2:0] MAC_A1   = 3'd3;
   localparam logic [2:0] MAC_A2   = 3'd4;
   localparam logic [2:0] MAC_LAST = 3'd5;   // drain of the last product

   typedef enum logic [2:0] {
      ST_CLEAR,      // zero the echo ring after reset
      ST_IDLE,       // wait for a request
      ST_MAC,        // biquad products through the shared multiplier
      ST_ABS,        // split the sum into sign and magnitude
      ST_DIV,        // restoring division by a0, one bit a cycle
      ST_COMB_RD,    // echo ring read
      ST_COMB_MUL,   // gain times echo through the shared multiplier
      ST_RESULT      // saturate, update state, hand over the result
   } state_type;

endpackage

### rtl/core/biquad_or_comb_audio_filter.sv
// Biquad (direct form I) or feedback comb audio filter, top level.
// Depends on bqcomb_pkg and biquad_or_comb_audio_filter_defines.svh.
`timescale 1ns / 1ps
//
// Usage:
//  - req_* carries one signed sample per request; rsp_* returns one saturated
//    sample per request, with rsp_tuser set when the output was clipped.
//  - csr_we/csr_addr/csr_wdata write a coefficient or the mode;
//    write only while no request is in flight.
//  - Biquad mode: five products on one shared multiplier, one sign split
//    step, then a restoring divide by a0 at one quotient bit a cycle, then
//    one result step. No new request is taken until the result step is done.
//  - Comb mode: ring read, multiply, result, in that order; the read of
//    the echo memory is registered.
//  - One request is in work at a time; req_tready is low meanwhile.
//  - After reset the echo memory is zeroed, one entry a cycle, with
//    req_tready low; configuration writes are taken meanwhile.
//  - When rsp_tready is low, the result register holds; the next request
//    may be accepted and worked on, and it waits in its result step until
//    the result register is free.

`include "biquad_or_comb_audio_filter_defines.svh"

module biquad_or_comb_audio_filter #(
   parameter int DELAY_LENGTH = bqcomb_pkg::DELAY_LENGTH_DEF,
   parameter int SAMPLE_WIDTH = bqcomb_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   req_tdata,   // in_sample
   // response channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   rsp_tdata,   // out_sample
   output logic                                rsp_tuser,   // clipped
   // configuration
   input  logic                                csr_we,
   input  logic [bqcomb_pkg::CSR_AW-1:0]       csr_addr,
   input  logic [bqcomb_pkg::CSR_DW-1:0]       csr_wdata
);

   localparam int SW      = SAMPLE_WIDTH;
   localparam int DATA_W  = ((SAMPLE_WIDTH + 7) / 8) * 8;
   localparam int COEF_W  = bqcomb_pkg::COEF_W;
   localparam int A0_W    = bqcomb_pkg::A0_W;
   localparam int PROD_W  = COEF_W + SW;
   localparam int ACC_W   = PROD_W + 3;
   localparam int CNT_W   = $clog2(ACC_W + 1);
   localparam int PTR_W   = (DELAY_LENGTH > 1) ? $clog2(DELAY_LENGTH) : 1;

   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DELAY_LENGTH - 1);
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(ACC_W - 1);
   localparam logic signed [ACC_W-1:0] SAT_HI =
      ACC_W'((64'sd1 <<< (SW - 1)) - 64'sd1);
   localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);
   localparam logic signed [PROD_W-1:0] COMB_RND = PROD_W'(bqcomb_pkg::COMB_ROUND);

   // Configuration registers
   logic                     mode_ff;
   logic [A0_W-1:0]          a0_ff;
   logic signed [COEF_W-1:0] a1_ff, a2_ff, b0_ff, b1_ff, b2_ff, gain_ff;

   // Sequencer and datapath registers
   bqcomb_pkg::state_type    state_ff, state_in;
   logic [2:0]               step_ff, step_in;
   logic [PTR_W-1:0]         clr_ff, clr_in;
   logic [PTR_W-1:0]         ptr_ff, ptr_in;
   logic signed [SW-1:0]     x_ff, x_in;
   logic signed [SW-1:0]     in_h1_ff, in_h1_in, in_h2_ff, in_h2_in;
   logic signed [SW-1:0]     out_h1_ff, out_h1_in, out_h2_ff, out_h2_in;
   logic signed [PROD_W-1:0] product_ff, product_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic [ACC_W-1:0]         quo_ff, quo_in;
   logic [A0_W:0]            rem_ff, rem_in;
   logic                     neg_ff, neg_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [SW-1:0]     rsp_sample_ff, rsp_sample_in;
   logic                     rsp_clip_ff, rsp_clip_in;

   // Echo ring
   logic signed [SW-1:0]     echo_mem [DELAY_LENGTH];
   logic signed [SW-1:0]     rd_data_ff;
   logic                     mem_we;
   logic [PTR_W-1:0]         mem_addr;
   logic signed [SW-1:0]     mem_wdata;

   // Combinational helpers
   logic signed [COEF_W-1:0] mul_coef;
   logic signed [SW-1:0]     mul_smp;
   logic                     req_fire;
   logic                     rsp_free;
   logic [A0_W-1:0]          divisor;
   logic [A0_W:0]            trial;
   logic [ACC_W-1:0]         acc_mag;
   logic signed [ACC_W-1:0]  quot_s;
   logic signed [PROD_W-1:0] comb_rnd_sum;
   logic signed [PROD_W-1:0] echo_val;
   logic signed [ACC_W-1:0]  comb_sum;
   logic signed [ACC_W-1:0]  sat_in;
   logic signed [SW-1:0]     sat_out;
   logic                     sat_clip;

   assign req_tready = (state_ff == bqcomb_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_W'($unsigned(rsp_sample_ff));
   assign rsp_tuser  = rsp_clip_ff;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= bqcomb_pkg::MODE_BIQUAD;
         a0_ff   <= bqcomb_pkg::A0_RESET;
         a1_ff   <= '0;
         a2_ff   <= '0;
         b0_ff   <= bqcomb_pkg::UNITY_COEF;
         b1_ff   <= '0;
         b2_ff   <= '0;
         gain_ff <= bqcomb_pkg::UNITY_COEF;
      end else if (csr_we) begin
         case (csr_addr)
            bqcomb_pkg::REG_FILTER_MODE: mode_ff <= csr_wdata[0];
            bqcomb_pkg::REG_COEF_A0:     a0_ff   <= csr_wdata[A0_W-1:0];
            bqcomb_pkg::REG_COEF_A1:     a1_ff   <= $signed(csr_wdata);
            bqcomb_pkg::REG_COEF_A2:     a2_ff   <= $signed(csr_wdata);
            bqcomb_pkg::REG_COEF_B0:     b0_ff   <= $signed(csr_wdata);
            bqcomb_pkg::REG_COEF_B1:     b1_ff   <= $signed(csr_wdata);
            bqcomb_pkg::REG_COEF_B2:     b2_ff   <= $signed(csr_wdata);
            bqcomb_pkg::REG_COMB_GAIN:   gain_ff <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   // Shared multiplier operand select
   always_comb begin
      mul_coef = '0;
      mul_smp  = '0;
      if (state_ff == bqcomb_pkg::ST_COMB_MUL) begin
         mul_coef = gain_ff;
         mul_smp  = rd_data_ff;
      end else begin
         case (step_ff)
            bqcomb_pkg::MAC_B0: begin mul_coef = b0_ff; mul_smp = x_ff;      end
            bqcomb_pkg::MAC_B1: begin mul_coef = b1_ff; mul_smp = in_h1_ff;  end
            bqcomb_pkg::MAC_B2: begin mul_coef = b2_ff; mul_smp = in_h2_ff;  end
            bqcomb_pkg::MAC_A1: begin mul_coef = a1_ff; mul_smp = out_h1_ff; end
            bqcomb_pkg::MAC_A2: begin mul_coef = a2_ff; mul_smp = out_h2_ff; end
            default: ;
         endcase
      end
   end

   // Divider step, sign handling, comb rounding and saturation
   always_comb begin
      divisor      = (a0_ff == '0) ? A0_W'(1) : a0_ff;
      trial        = {rem_ff[A0_W-1:0], quo_ff[ACC_W-1]};
      acc_mag      = acc_ff[ACC_W-1] ? $unsigned(-acc_ff) : $unsigned(acc_ff);
      quot_s       = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);
      comb_rnd_sum = product_ff + COMB_RND;
      echo_val     = comb_rnd_sum >>> bqcomb_pkg::COMB_SHIFT;
      comb_sum     = ACC_W'(x_ff) + ACC_W'(echo_val);
      sat_in       = (mode_ff == bqcomb_pkg::MODE_COMB) ? comb_sum : quot_s;
      sat_clip     = 1'b1;
      if (sat_in > SAT_HI) begin
         sat_out = SAT_HI[SW-1:0];
      end else if (sat_in < SAT_LO) begin
         sat_out = SAT_LO[SW-1:0];
      end else begin
         sat_out  = sat_in[SW-1:0];
         sat_clip = 1'b0;
      end
   end

   // Sequencer: next state and datapath updates
   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      clr_in        = clr_ff;
      ptr_in        = ptr_ff;
      x_in          = x_ff;
      in_h1_in      = in_h1_ff;
      in_h2_in      = in_h2_ff;
      out_h1_in     = out_h1_ff;
      out_h2_in     = out_h2_ff;
      product_in    = product_ff;
      acc_in        = acc_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      neg_in        = neg_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_sample_in = rsp_sample_ff;
      rsp_clip_in   = rsp_clip_ff;
      mem_we        = 1'b0;
      mem_addr      = ptr_ff;
      mem_wdata     = sat_out;

      case (state_ff)
         bqcomb_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_addr  = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + PTR_W'(1);
            if (clr_ff == PTR_LAST) begin
               state_in = bqcomb_pkg::ST_IDLE;
            end
         end
         bqcomb_pkg::ST_IDLE: begin
            if (req_fire) begin
               x_in    = $signed(req_tdata[SW-1:0]);
               step_in = bqcomb_pkg::MAC_B0;
               acc_in  = '0;
               if (mode_ff == bqcomb_pkg::MODE_COMB) begin
                  state_in = bqcomb_pkg::ST_COMB_RD;
               end else begin
                  state_in = bqcomb_pkg::ST_MAC;
               end
            end
         end
         bqcomb_pkg::ST_MAC: begin
            product_in = mul_coef * mul_smp;
            // product of the previous step lands in the accumulator
            if (step_ff != bqcomb_pkg::MAC_B0) begin
               if (step_ff > bqcomb_pkg::MAC_A1) begin
                  acc_in = acc_ff - ACC_W'(product_ff);
               end else begin
                  acc_in = acc_ff + ACC_W'(product_ff);
               end
            end
            step_in = step_ff + 3'd1;
            if (step_ff == bqcomb_pkg::MAC_LAST) begin
               state_in = bqcomb_pkg::ST_ABS;
            end
         end
         bqcomb_pkg::ST_ABS: begin
            quo_in   = acc_mag;
            neg_in   = acc_ff[ACC_W-1];
            rem_in   = '0;
            cnt_in   = '0;
            state_in = bqcomb_pkg::ST_DIV;
         end
         bqcomb_pkg::ST_DIV: begin
            if (trial >= {1'b0, divisor}) begin
               rem_in = trial - {1'b0, divisor};
               quo_in = {quo_ff[ACC_W-2:0], 1'b1};
            end else begin
               rem_in = trial;
               quo_in = {quo_ff[ACC_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == DIV_LAST) begin
               state_in = bqcomb_pkg::ST_RESULT;
            end
         end
         bqcomb_pkg::ST_COMB_RD: begin
            state_in = bqcomb_pkg::ST_COMB_MUL;
         end
         bqcomb_pkg::ST_COMB_MUL: begin
            // product holds until the result step hands it over
            product_in = mul_coef * mul_smp;
            state_in   = bqcomb_pkg::ST_RESULT;
         end
         bqcomb_pkg::ST_RESULT: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = sat_out;
               rsp_clip_in   = sat_clip;
               state_in      = bqcomb_pkg::ST_IDLE;
               if (mode_ff == bqcomb_pkg::MODE_COMB) begin
                  mem_we = 1'b1;
                  ptr_in = (ptr_ff == PTR_LAST) ? '0 : ptr_ff + PTR_W'(1);
               end else begin
                  in_h2_in  = in_h1_ff;
                  in_h1_in  = x_ff;
                  out_h2_in = out_h1_ff;
                  out_h1_in = sat_out;
               end
            end
         end
         default: begin
            state_in = bqcomb_pkg::ST_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bqcomb_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control and filter state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         ptr_ff       <= '0;
         step_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         in_h1_ff     <= '0;
         in_h2_ff     <= '0;
         out_h1_ff    <= '0;
         out_h2_ff    <= '0;
      end else begin
         clr_ff       <= clr_in;
         ptr_ff       <= ptr_in;
         step_ff      <= step_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         in_h1_ff     <= in_h1_in;
         in_h2_ff     <= in_h2_in;
         out_h1_ff    <= out_h1_in;
         out_h2_ff    <= out_h2_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      product_ff    <= product_in;
      acc_ff        <= acc_in;
      quo_ff        <= quo_in;
      rem_ff        <= rem_in;
      neg_ff        <= neg_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_clip_ff   <= rsp_clip_in;
   end

   // Echo ring: one write port, registered read at the ring pointer
   always_ff @(posedge clock) begin
      if (mem_we) begin
         echo_mem[mem_addr] <= mem_wdata;
      end
      rd_data_ff <= echo_mem[ptr_ff];
   end

   // Assertions
   `BQC_ASSERT_ALWAYS(a_clear_after_reset, clock, reset |=> !req_tready,
      "request taken before the echo ring was cleared")
   `BQC_ASSERT(a_busy_after_accept, clock, reset,
      req_tvalid && req_tready |=> !req_tready,
      "second request taken while one is in work")
   `BQC_ASSERT(a_rsp_from_result, clock, reset,
      $rose(rsp_tvalid) |-> $past(state_ff == bqcomb_pkg::ST_RESULT),
      "response raised outside the result step")
   `BQC_ASSERT(a_div_count_range, clock, reset,
      (state_ff == bqcomb_pkg::ST_DIV) |-> (cnt_ff <= DIV_LAST),
      "divider ran past its last quotient bit")

endmodule
